// ===== hdl/dftr_pkg.sv =====
package dftr_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd1;

	localparam logic [30:0] THRESHOLD_RST = 31'd1000;
	localparam logic [15:0] PERIOD_RST    = 16'd1000;
	localparam logic [16:0] PERIOD_MAX    = 17'd65535;

	localparam logic [15:0] DNS_PORT      = 16'd53;
	localparam logic [15:0] DNS_HDR_BYTES = 16'd12;
	localparam logic [15:0] FLAG_QR_TC    = 16'h8200;

	// 0x4500 + 40 + 0x4000 (DF) + 0x4011 (ttl 64, udp)
	localparam logic [18:0] IP_CONST_SUM  = 19'h0C539;
	// proto 17 + udp len 20 + src port 53 + udp len 20
	localparam logic [19:0] UDP_CONST_SUM = 20'd110;

	localparam int TDATA_W = 192;
	localparam int TUSER_W = 2;

	typedef struct packed {
		logic [15:0] ar_count;
		logic [15:0] ns_count;
		logic [15:0] an_count;
		logic [15:0] dns_flags;
		logic [15:0] dns_id;
		logic [15:0] dns_len;
		logic [15:0] dport;
		logic [15:0] src_port;
		logic [31:0] dst_ip;
		logic [31:0] src_ip;
	} pkt_t;

	typedef struct packed {
		logic tick;
		logic count;
	} ctrl_ev_t;

endpackage

// ===== hdl/dns_flood_truncation_responder.sv =====
// Channel  | Dir | Handshake          | Payload
// s        | in  | s_tvalid/s_tready  | s_tdata packet fields, s_tuser type and udp flag
// m        | out | m_tvalid/m_tready  | m_tdata reply fields, m_tuser verdict and reply flag
// cfg      | in  | cfg_we             | cfg_addr register index, cfg_wdata value
// One request per cycle sustained while m_tready holds; a packet passes the input register, then the result register.
// Ticks pass through the input register, update the period counters and produce no result.
// Flood state is read and updated in the input stage, so back-to-back requests see it current.
// A stalled result register holds its packet; ticks still drain behind it.
// arst_n clears the counters and flood mode and loads the register defaults.
module dns_flood_truncation_responder import dftr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// src_ip, dst_ip, src_port, dport, dns_len, dns_id, dns_flags,
	// an_count, ns_count, ar_count
	input  logic [TDATA_W-1:0]    s_tdata,
	// req_type, is_ipv4_udp
	input  logic [TUSER_W-1:0]    s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// reply_src_ip, reply_dst_ip, reply_dport, reply_ip_checksum,
	// reply_udp_checksum, reply_dns_id, reply_dns_flags, reply_an_count,
	// reply_ns_count, reply_ar_count
	output logic [TDATA_W-1:0]    m_tdata,
	// verdict, reply_valid
	output logic [TUSER_W-1:0]    m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic                vld_s1;
	logic                tick_s1;
	logic                udp_s1;
	pkt_t                pkt_s1;
	logic                res_vld_s2;
	logic [TDATA_W-1:0]  res_data_s2;
	logic [TUSER_W-1:0]  res_user_s2;

	logic                adv;
	logic                is_dns;
	logic                runt;
	logic                counted;
	logic                reply;
	logic                verdict;
	logic                flood;
	logic [15:0]         flags_or;
	logic [15:0]         ip_ck;
	logic [15:0]         udp_ck;
	logic [TDATA_W-1:0]  reply_data;
	ctrl_ev_t            ev;

	assign adv      = vld_s1 && (tick_s1 || !res_vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1 <= s_tuser[0];
			udp_s1  <= s_tuser[1];
			pkt_s1  <= s_tdata;
		end
	end

	assign is_dns   = udp_s1 && pkt_s1.dport == DNS_PORT;
	assign runt     = pkt_s1.dns_len < DNS_HDR_BYTES;
	assign counted  = is_dns && !runt;
	assign reply    = counted && flood;
	assign verdict  = is_dns && (runt || flood);
	assign flags_or = pkt_s1.dns_flags | FLAG_QR_TC;

	assign ev.tick  = adv && tick_s1;
	assign ev.count = adv && !tick_s1 && counted;

	dftr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.ev        (ev),
		.flood     (flood)
	);

	dftr_csum u_csum (
		.sip    (pkt_s1.src_ip),
		.dip    (pkt_s1.dst_ip),
		.sport  (pkt_s1.src_port),
		.id     (pkt_s1.dns_id),
		.flags  (flags_or),
		.an     (pkt_s1.an_count),
		.ns     (pkt_s1.ns_count),
		.ar     (pkt_s1.ar_count),
		.ip_ck  (ip_ck),
		.udp_ck (udp_ck)
	);

	assign reply_data = {pkt_s1.ar_count, pkt_s1.ns_count, pkt_s1.an_count, flags_or,
		pkt_s1.dns_id, udp_ck, ip_ck, pkt_s1.src_port, pkt_s1.src_ip, pkt_s1.dst_ip};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else if (adv && !tick_s1) begin
			res_vld_s2 <= 1'b1;
		end else if (m_tready) begin
			res_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && !tick_s1) begin
			res_data_s2 <= reply ? reply_data : '0;
			res_user_s2 <= {reply, verdict};
		end
	end

	assign m_tvalid = res_vld_s2;
	assign m_tdata  = res_data_s2;
	assign m_tuser  = res_user_s2;

	a_reply_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> m_tuser[0])
		else $error("reply emitted for an accepted packet");

	a_no_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> m_tdata == '0)
		else $error("reply fields not cleared without a reply");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_s2 && !m_tready) |-> !(adv && !tick_s1))
		else $error("stalled result overwritten");

endmodule

// ===== hdl/dftr_ctrl.sv =====
module dftr_ctrl import dftr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  ctrl_ev_t             ev,
	output logic                 flood
);

	logic [30:0] threshold_q;
	logic [15:0] period_q;
	logic [31:0] qcount_q;
	logic [15:0] tcount_q;
	logic        flood_q;
	logic [16:0] tick_next;
	logic        period_end;

	assign tick_next  = {1'b0, tcount_q} + 17'd1;
	assign period_end = tick_next >= {1'b0, period_q};
	assign flood      = flood_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			period_q    <= PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_THRESHOLD: begin
					if (cfg_wdata != '0)
						threshold_q <= cfg_wdata;
				end
				REG_PERIOD: begin
					if (cfg_wdata[15:0] != 16'd0 && {1'b0, cfg_wdata[15:0]} <= PERIOD_MAX)
						period_q <= cfg_wdata[15:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcount_q <= '0;
			tcount_q <= '0;
			flood_q  <= 1'b0;
		end else if (ev.tick) begin
			if (period_end) begin
				flood_q  <= qcount_q > {1'b0, threshold_q};
				qcount_q <= '0;
				tcount_q <= '0;
			end else begin
				tcount_q <= tick_next[15:0];
			end
		end else if (ev.count && qcount_q != '1) begin
			qcount_q <= qcount_q + 32'd1;
		end
	end

	a_flood_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(flood_q) |-> $past(ev.tick))
		else $error("flood mode changed without a period end");

	a_clear_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(qcount_q == '0 && $past(qcount_q) != '0) |-> $past(ev.tick && period_end))
		else $error("query count cleared outside period end");

	a_no_count_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		ev.tick |-> !ev.count)
		else $error("tick and count in one cycle");

endmodule

// ===== hdl/dftr_csum.sv =====
module dftr_csum import dftr_pkg::*; (
	input  logic [31:0] sip,
	input  logic [31:0] dip,
	input  logic [15:0] sport,
	input  logic [15:0] id,
	input  logic [15:0] flags,
	input  logic [15:0] an,
	input  logic [15:0] ns,
	input  logic [15:0] ar,
	output logic [15:0] ip_ck,
	output logic [15:0] udp_ck
);

	logic [18:0] addr_sum;
	logic [18:0] ip_sum;
	logic [16:0] ip_f1;
	logic [15:0] ip_f2;
	logic [19:0] udp_sum;
	logic [16:0] udp_f1;
	logic [15:0] udp_f2;
	logic [15:0] udp_raw;

	assign addr_sum = {3'b0, dip[31:16]} + {3'b0, dip[15:0]}
		+ {3'b0, sip[31:16]} + {3'b0, sip[15:0]};

	assign ip_sum = IP_CONST_SUM + addr_sum;
	assign ip_f1  = {1'b0, ip_sum[15:0]} + {14'b0, ip_sum[18:16]};
	assign ip_f2  = ip_f1[15:0] + {15'b0, ip_f1[16]};
	assign ip_ck  = ~ip_f2;

	assign udp_sum = UDP_CONST_SUM + {1'b0, addr_sum}
		+ {4'b0, sport} + {4'b0, id} + {4'b0, flags}
		+ {4'b0, an} + {4'b0, ns} + {4'b0, ar};
	assign udp_f1  = {1'b0, udp_sum[15:0]} + {13'b0, udp_sum[19:16]};
	assign udp_f2  = udp_f1[15:0] + {15'b0, udp_f1[16]};
	assign udp_raw = ~udp_f2;
	assign udp_ck  = (udp_raw == 16'd0) ? 16'hFFFF : udp_raw;

endmodule
